// ===== rtl/core/sfdq_pkg.sv =====
package sfdq_pkg;

    localparam int PEER_SLOTS  = 256;
    localparam int QUEUE_DEPTH = 64;
    localparam int SLOT_W      = $clog2(PEER_SLOTS);
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int RING_CNT_W  = $clog2(PEER_SLOTS + 1);
    localparam int DESC_AW     = SLOT_W + QIDX_W;
    localparam int DESC_DEPTH  = PEER_SLOTS * QUEUE_DEPTH;
    localparam int LIMIT_W     = 7;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    localparam logic [2:0] OP_ARRIVAL = 3'd0;
    localparam logic [2:0] OP_ACCEPT  = 3'd1;
    localparam logic [2:0] OP_RECEIVE = 3'd2;
    localparam logic [2:0] OP_PCLOSE  = 3'd3;
    localparam logic [2:0] OP_LCLOSE  = 3'd4;

    localparam logic [3:0] ST_QUEUED     = 4'd0;
    localparam logic [3:0] ST_DROPPED    = 4'd1;
    localparam logic [3:0] ST_NO_SLOT    = 4'd2;
    localparam logic [3:0] ST_CLOSED     = 4'd3;
    localparam logic [3:0] ST_PENDING    = 4'd4;
    localparam logic [3:0] ST_ACCEPTED   = 4'd5;
    localparam logic [3:0] ST_EMPTY      = 4'd6;
    localparam logic [3:0] ST_NEED_CAP   = 4'd7;
    localparam logic [3:0] ST_RECEIVED   = 4'd8;
    localparam logic [3:0] ST_RELEASED   = 4'd9;
    localparam logic [3:0] ST_CLOSE_DONE = 4'd10;

    localparam logic [1:0] FAM_IPV4 = 2'd0;
    localparam logic [1:0] FAM_IPV6 = 2'd1;

    typedef struct packed {
        logic [2:0]  op;
        logic [1:0]  family;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [15:0] src_port;
        logic [7:0]  peer_slot;
        logic [15:0] pkt_length;
        logic [15:0] pkt_handle;
        logic [15:0] capacity;
    } in_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [7:0]  out_slot;
        logic [15:0] out_length;
        logic [15:0] out_handle;
        logic        new_peer;
        logic        last;
    } out_t;

    typedef struct packed {
        logic [1:0]  family;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [15:0] src_port;
    } tag_t;

    typedef struct packed {
        logic [15:0] length;
        logic [15:0] handle;
    } desc_t;

    typedef struct packed {
        logic               en;
        logic               we;
        logic [DESC_AW-1:0] addr;
        desc_t              data;
    } desc_req_t;

    typedef struct packed {
        logic              done;
        logic              hit;
        logic              has_free;
        logic [SLOT_W-1:0] slot;
    } lookup_res_t;

    typedef struct packed {
        logic [QIDX_W-1:0] head;
        logic [FILL_W-1:0] fill;
    } qstate_t;

    function automatic logic source_match(tag_t t, tag_t k);
        logic m;
        m = 1'b0;
        if (t.family == k.family && t.src_port == k.src_port) begin
            if (k.family == FAM_IPV4) begin
                m = (t.addr_low[31:0] == k.addr_low[31:0]);
            end else if (k.family == FAM_IPV6) begin
                m = (t.addr_high == k.addr_high) && (t.addr_low == k.addr_low);
            end
        end
        return m;
    endfunction

    function automatic logic [FILL_W-1:0] eff_limit(logic [LIMIT_W-1:0] lim);
        logic [FILL_W-1:0] r;
        if (lim == '0) begin
            r = FILL_W'(1);
        end else if (32'(lim) > QUEUE_DEPTH) begin
            r = FILL_W'(QUEUE_DEPTH);
        end else begin
            r = FILL_W'(lim);
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/sfdq_desc_store.sv =====
module sfdq_desc_store (
    input  logic                clk,
    input  sfdq_pkg::desc_req_t req,
    output sfdq_pkg::desc_t     rd_data
);

    sfdq_pkg::desc_t mem [sfdq_pkg::DESC_DEPTH];
    sfdq_pkg::desc_t rd_reg;

    always_ff @(posedge clk)
    begin
        if (req.en) begin
            if (req.we) begin
                mem[req.addr] <= req.data;
            end else begin
                rd_reg <= mem[req.addr];
            end
        end
    end

    assign rd_data = rd_reg;

endmodule

// ===== rtl/core/sfdq_lookup.sv =====
module sfdq_lookup (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  sfdq_pkg::tag_t                key,
    output sfdq_pkg::lookup_res_t         res,
    input  logic                          alloc_we,
    input  logic [sfdq_pkg::SLOT_W-1:0]   alloc_slot,
    input  sfdq_pkg::tag_t                alloc_tag,
    input  logic                          clear_en,
    input  logic [sfdq_pkg::SLOT_W-1:0]   clear_slot,
    input  logic [sfdq_pkg::SLOT_W-1:0]   qry_slot,
    output logic                          qry_used
);

    sfdq_pkg::tag_t tag_mem [sfdq_pkg::PEER_SLOTS];
    sfdq_pkg::tag_t tag_rd_reg;

    logic [sfdq_pkg::PEER_SLOTS-1:0] used_reg;
    logic                            active_reg;
    logic [sfdq_pkg::SLOT_W:0]       idx_reg;
    logic                            dv_reg;
    logic [sfdq_pkg::SLOT_W-1:0]     didx_reg;
    logic                            free_found_reg;
    logic [sfdq_pkg::SLOT_W-1:0]     free_slot_reg;

    logic match;
    logic last_entry;
    logic done;
    logic issue;
    logic [sfdq_pkg::SLOT_W-1:0] idx_s;

    assign idx_s      = idx_reg[sfdq_pkg::SLOT_W-1:0];
    assign match      = dv_reg && used_reg[didx_reg]
                        && sfdq_pkg::source_match(tag_rd_reg, key);
    assign last_entry = dv_reg && (didx_reg == sfdq_pkg::SLOT_W'(sfdq_pkg::PEER_SLOTS - 1));
    assign done       = active_reg && (match || last_entry);
    assign issue      = active_reg && !done
                        && (32'(idx_reg) < sfdq_pkg::PEER_SLOTS);

    assign res.done     = done;
    assign res.hit      = match;
    assign res.has_free = free_found_reg;
    assign res.slot     = match ? didx_reg : free_slot_reg;
    assign qry_used     = used_reg[qry_slot];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            used_reg       <= '0;
            active_reg     <= 1'b0;
            idx_reg        <= '0;
            dv_reg         <= 1'b0;
            free_found_reg <= 1'b0;
        end else begin
            if (alloc_we) begin
                used_reg[alloc_slot] <= 1'b1;
            end
            if (clear_en) begin
                used_reg[clear_slot] <= 1'b0;
            end
            if (start) begin
                active_reg     <= 1'b1;
                idx_reg        <= '0;
                dv_reg         <= 1'b0;
                free_found_reg <= 1'b0;
            end else if (done) begin
                active_reg <= 1'b0;
                dv_reg     <= 1'b0;
            end else begin
                dv_reg <= issue;
                if (issue) begin
                    idx_reg <= idx_reg + 1'b1;
                    if (!free_found_reg && !used_reg[idx_s]) begin
                        free_found_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // scan pipeline payload: one tag read per cycle, compared in the cycle after the read
    always_ff @(posedge clk)
    begin
        if (issue) begin
            tag_rd_reg <= tag_mem[idx_s];
            didx_reg   <= idx_s;
            if (!free_found_reg && !used_reg[idx_s]) begin
                free_slot_reg <= idx_s;
            end
        end
        if (alloc_we) begin
            tag_mem[alloc_slot] <= alloc_tag;
        end
    end

endmodule

// ===== rtl/core/source_flow_demux_queues_unit.sv =====
// per-source datagram demultiplexer with drop-oldest queues per peer slot
// input channel: in_valid/in_stall carry one operation item (in_data); the
// unit stalls input while it works on an item, one item at a time
// output channel: out_valid/out_stall carry result items (out_data); a
// registered output stage holds a result while the receiver stalls, and the
// unit waits on it before producing the next result
// config channel: cfg_valid/cfg_ready write queue_limit, always ready
// operation: an arrival scans the slot tag memory one entry per cycle and
// stops early on a match; peer close emits one released result for each
// descriptor held in the slot's queue
// reset: all slots free, arrival ring empty, intake open, queue_limit 64;
// the tag, queue state and descriptor memories are not cleared, per-slot
// used bits gate every read of them
module source_flow_demux_queues_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  sfdq_pkg::in_t                   in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output sfdq_pkg::out_t                  out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sfdq_pkg::LIMIT_W-1:0]    cfg_data
);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_DISPATCH   = 4'd1;
    localparam logic [3:0] S_LOOKUP     = 4'd2;
    localparam logic [3:0] S_QRD        = 4'd3;
    localparam logic [3:0] S_DRD        = 4'd4;
    localparam logic [3:0] S_RING       = 4'd5;
    localparam logic [3:0] S_EMIT       = 4'd6;
    localparam logic [3:0] S_CLOSE_RD   = 4'd7;
    localparam logic [3:0] S_CLOSE_EMIT = 4'd8;

    localparam int SW = sfdq_pkg::SLOT_W;
    localparam int QW = sfdq_pkg::QIDX_W;
    localparam int FW = sfdq_pkg::FILL_W;

    logic [3:0]                          state_reg, state_next;
    sfdq_pkg::in_t                       item_reg, item_next;
    sfdq_pkg::out_t                      res_reg, res_next;
    logic [SW-1:0]                       slot_reg, slot_next;
    logic [FW-1:0]                       cnt_reg, cnt_next;
    logic [SW-1:0]                       arr_head_reg, arr_head_next;
    logic [sfdq_pkg::RING_CNT_W-1:0]     arr_fill_reg, arr_fill_next;
    logic                                closed_reg, closed_next;
    logic [sfdq_pkg::LIMIT_W-1:0]        limit_reg, limit_next;
    logic                                out_valid_reg, out_valid_next;
    sfdq_pkg::out_t                      out_data_reg, out_data_next;

    sfdq_pkg::qstate_t qs_mem [sfdq_pkg::PEER_SLOTS];
    sfdq_pkg::qstate_t qs_rd_reg;
    logic [SW-1:0]     ring_mem [sfdq_pkg::PEER_SLOTS];
    logic [SW-1:0]     ring_rd_reg;

    logic              q_rd_en;
    logic [SW-1:0]     q_rd_addr;
    logic              q_we;
    logic [SW-1:0]     q_wr_addr;
    sfdq_pkg::qstate_t q_wr_data;
    logic              ring_we;
    logic [SW-1:0]     ring_waddr;

    sfdq_pkg::desc_req_t   desc_req;
    sfdq_pkg::desc_t       desc_rd;
    sfdq_pkg::lookup_res_t lk_res;
    sfdq_pkg::tag_t        key;
    logic                  lk_start;
    logic                  alloc_we;
    logic                  clear_en;
    logic                  qry_used;

    logic              out_free;
    logic              out_load;
    sfdq_pkg::out_t    out_load_data;
    logic              bad_slot;
    logic [SW-1:0]     ps_slot;
    logic [FW-1:0]     lim;
    logic [QW-1:0]     tail_idx;
    logic              close_last;

    assign key.family    = item_reg.family;
    assign key.addr_high = item_reg.addr_high;
    assign key.addr_low  = item_reg.addr_low;
    assign key.src_port  = item_reg.src_port;

    assign ps_slot    = item_reg.peer_slot[SW-1:0];
    assign bad_slot   = (32'(item_reg.peer_slot) >= sfdq_pkg::PEER_SLOTS);
    assign lim        = sfdq_pkg::eff_limit(limit_reg);
    assign tail_idx   = qs_rd_reg.head + qs_rd_reg.fill[QW-1:0];
    assign close_last = ((cnt_reg + 1'b1) == qs_rd_reg.fill);
    assign out_free   = !out_valid_reg || !out_stall;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    sfdq_lookup u_lookup (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (lk_start),
        .key        (key),
        .res        (lk_res),
        .alloc_we   (alloc_we),
        .alloc_slot (lk_res.slot),
        .alloc_tag  (key),
        .clear_en   (clear_en),
        .clear_slot (slot_reg),
        .qry_slot   (ps_slot),
        .qry_used   (qry_used)
    );

    sfdq_desc_store u_desc (
        .clk     (clk),
        .req     (desc_req),
        .rd_data (desc_rd)
    );

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        slot_next      = slot_reg;
        cnt_next       = cnt_reg;
        arr_head_next  = arr_head_reg;
        arr_fill_next  = arr_fill_reg;
        closed_next    = closed_reg;
        limit_next     = limit_reg;
        q_rd_en        = 1'b0;
        q_rd_addr      = slot_reg;
        q_we           = 1'b0;
        q_wr_addr      = slot_reg;
        q_wr_data      = qs_rd_reg;
        ring_we        = 1'b0;
        ring_waddr     = arr_head_reg + arr_fill_reg[SW-1:0];
        desc_req       = '0;
        lk_start       = 1'b0;
        alloc_we       = 1'b0;
        clear_en       = 1'b0;
        out_load       = 1'b0;
        out_load_data  = res_reg;

        if (cfg_valid) begin
            limit_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    item_next  = in_data;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                res_next   = '0;
                res_next.last = 1'b1;
                slot_next  = ps_slot;
                state_next = S_EMIT;
                case (item_reg.op)
                    sfdq_pkg::OP_ARRIVAL:
                    begin
                        if (closed_reg) begin
                            res_next.status     = sfdq_pkg::ST_CLOSED;
                            res_next.out_handle = item_reg.pkt_handle;
                        end else begin
                            lk_start   = 1'b1;
                            state_next = S_LOOKUP;
                        end
                    end
                    sfdq_pkg::OP_ACCEPT:
                    begin
                        if (closed_reg) begin
                            res_next.status = sfdq_pkg::ST_CLOSED;
                        end else if (arr_fill_reg == '0) begin
                            res_next.status = sfdq_pkg::ST_PENDING;
                        end else begin
                            state_next = S_RING;
                        end
                    end
                    sfdq_pkg::OP_RECEIVE:
                    begin
                        res_next.out_slot = item_reg.peer_slot;
                        if (bad_slot || !qry_used) begin
                            res_next.status = sfdq_pkg::ST_CLOSED;
                        end else begin
                            q_rd_en    = 1'b1;
                            q_rd_addr  = ps_slot;
                            state_next = S_QRD;
                        end
                    end
                    sfdq_pkg::OP_PCLOSE:
                    begin
                        res_next.out_slot = item_reg.peer_slot;
                        // an unused slot never holds descriptors
                        if (bad_slot || !qry_used) begin
                            res_next.status = sfdq_pkg::ST_CLOSE_DONE;
                        end else begin
                            q_rd_en    = 1'b1;
                            q_rd_addr  = ps_slot;
                            state_next = S_QRD;
                        end
                    end
                    sfdq_pkg::OP_LCLOSE:
                    begin
                        closed_next     = 1'b1;
                        res_next.status = sfdq_pkg::ST_CLOSE_DONE;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_LOOKUP:
            begin
                if (lk_res.done) begin
                    slot_next  = lk_res.slot;
                    res_next.out_slot   = 8'(lk_res.slot);
                    res_next.out_handle = item_reg.pkt_handle;
                    state_next = S_EMIT;
                    if (lk_res.hit) begin
                        q_rd_en    = 1'b1;
                        q_rd_addr  = lk_res.slot;
                        state_next = S_QRD;
                    end else if (lk_res.has_free) begin
                        alloc_we = 1'b1;
                        if (32'(arr_fill_reg) < sfdq_pkg::PEER_SLOTS) begin
                            ring_we       = 1'b1;
                            arr_fill_next = arr_fill_reg + 1'b1;
                        end
                        desc_req.en          = 1'b1;
                        desc_req.we          = 1'b1;
                        desc_req.addr        = {lk_res.slot, QW'(0)};
                        desc_req.data.length = item_reg.pkt_length;
                        desc_req.data.handle = item_reg.pkt_handle;
                        q_we                 = 1'b1;
                        q_wr_addr            = lk_res.slot;
                        q_wr_data.head       = '0;
                        q_wr_data.fill       = FW'(1);
                        res_next.status      = sfdq_pkg::ST_QUEUED;
                        res_next.new_peer    = 1'b1;
                    end else begin
                        res_next.status   = sfdq_pkg::ST_NO_SLOT;
                        res_next.out_slot = '0;
                    end
                end
            end
            S_QRD:
            begin
                state_next = S_EMIT;
                case (item_reg.op)
                    sfdq_pkg::OP_ARRIVAL:
                    begin
                        if (qs_rd_reg.fill >= lim) begin
                            desc_req.en   = 1'b1;
                            desc_req.addr = {slot_reg, qs_rd_reg.head};
                            state_next    = S_DRD;
                        end else begin
                            desc_req.en          = 1'b1;
                            desc_req.we          = 1'b1;
                            desc_req.addr        = {slot_reg, tail_idx};
                            desc_req.data.length = item_reg.pkt_length;
                            desc_req.data.handle = item_reg.pkt_handle;
                            q_we                 = 1'b1;
                            q_wr_data.fill       = qs_rd_reg.fill + 1'b1;
                            res_next.status      = sfdq_pkg::ST_QUEUED;
                        end
                    end
                    sfdq_pkg::OP_RECEIVE:
                    begin
                        if (qs_rd_reg.fill == '0) begin
                            res_next.status = sfdq_pkg::ST_EMPTY;
                        end else begin
                            desc_req.en   = 1'b1;
                            desc_req.addr = {slot_reg, qs_rd_reg.head};
                            state_next    = S_DRD;
                        end
                    end
                    default:
                    begin
                        // peer close of a slot in use
                        if (qs_rd_reg.fill == '0) begin
                            clear_en        = 1'b1;
                            res_next.status = sfdq_pkg::ST_CLOSE_DONE;
                        end else begin
                            cnt_next   = '0;
                            state_next = S_CLOSE_RD;
                        end
                    end
                endcase
            end
            S_DRD:
            begin
                state_next = S_EMIT;
                if (item_reg.op == sfdq_pkg::OP_ARRIVAL) begin
                    // drop oldest, append at the same tail position
                    desc_req.en          = 1'b1;
                    desc_req.we          = 1'b1;
                    desc_req.addr        = {slot_reg, tail_idx};
                    desc_req.data.length = item_reg.pkt_length;
                    desc_req.data.handle = item_reg.pkt_handle;
                    q_we                 = 1'b1;
                    q_wr_data.head       = qs_rd_reg.head + 1'b1;
                    res_next.status      = sfdq_pkg::ST_DROPPED;
                    res_next.out_handle  = desc_rd.handle;
                end else if (desc_rd.length > item_reg.capacity) begin
                    res_next.status     = sfdq_pkg::ST_NEED_CAP;
                    res_next.out_length = desc_rd.length;
                end else begin
                    q_we                = 1'b1;
                    q_wr_data.head      = qs_rd_reg.head + 1'b1;
                    q_wr_data.fill      = qs_rd_reg.fill - 1'b1;
                    res_next.status     = sfdq_pkg::ST_RECEIVED;
                    res_next.out_length = desc_rd.length;
                    res_next.out_handle = desc_rd.handle;
                end
            end
            S_RING:
            begin
                res_next.status   = sfdq_pkg::ST_ACCEPTED;
                res_next.out_slot = 8'(ring_rd_reg);
                arr_head_next     = arr_head_reg + 1'b1;
                arr_fill_next     = arr_fill_reg - 1'b1;
                state_next        = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CLOSE_RD:
            begin
                desc_req.en   = 1'b1;
                desc_req.addr = {slot_reg, qs_rd_reg.head + cnt_reg[QW-1:0]};
                state_next    = S_CLOSE_EMIT;
            end
            S_CLOSE_EMIT:
            begin
                if (out_free) begin
                    out_load                 = 1'b1;
                    out_load_data            = '0;
                    out_load_data.status     = sfdq_pkg::ST_RELEASED;
                    out_load_data.out_slot   = 8'(slot_reg);
                    out_load_data.out_length = desc_rd.length;
                    out_load_data.out_handle = desc_rd.handle;
                    out_load_data.last       = close_last;
                    if (close_last) begin
                        clear_en   = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = S_CLOSE_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (out_valid_reg && out_stall);
        out_data_next  = out_load ? out_load_data : out_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            arr_head_reg  <= '0;
            arr_fill_reg  <= '0;
            closed_reg    <= 1'b0;
            limit_reg     <= sfdq_pkg::LIMIT_RESET;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            arr_head_reg  <= arr_head_next;
            arr_fill_reg  <= arr_fill_next;
            closed_reg    <= closed_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        res_reg      <= res_next;
        slot_reg     <= slot_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_we) begin
            qs_mem[q_wr_addr] <= q_wr_data;
        end
        if (q_rd_en) begin
            qs_rd_reg <= qs_mem[q_rd_addr];
        end
        if (ring_we) begin
            ring_mem[ring_waddr] <= lk_res.slot;
        end
        ring_rd_reg <= ring_mem[arr_head_reg];
    end

    a_ring_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(arr_fill_reg) <= sfdq_pkg::PEER_SLOTS)
        else $error("arrival ring fill above slot count");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over a held result");

    a_qfill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_we |-> (32'(q_wr_data.fill) <= sfdq_pkg::QUEUE_DEPTH))
        else $error("queue fill above depth");

    a_lookup_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        lk_res.done |-> (state_reg == S_LOOKUP))
        else $error("lookup finished outside lookup state");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_DISPATCH))
        else $error("accepted item not dispatched");

endmodule

// ===== test/testbench.sv =====
module testbench;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_WAIT  = 400;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    sfdq_pkg::in_t  in_data;
    logic out_valid;
    logic out_stall;
    sfdq_pkg::out_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [sfdq_pkg::LIMIT_W-1:0] cfg_data;

    source_flow_demux_queues_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // shadow copy of the demux state
    logic                         peer_used [sfdq_pkg::PEER_SLOTS];
    sfdq_pkg::tag_t               peer_tag [sfdq_pkg::PEER_SLOTS];
    int                           peer_head [sfdq_pkg::PEER_SLOTS];
    int                           peer_fill [sfdq_pkg::PEER_SLOTS];
    sfdq_pkg::desc_t              desc_store [sfdq_pkg::DESC_DEPTH];
    int                           accept_ring [sfdq_pkg::PEER_SLOTS];
    int                           ring_head;
    int                           ring_fill;
    logic                         intake_shut;
    logic [sfdq_pkg::LIMIT_W-1:0] limit_reg;

    sfdq_pkg::out_t pending_results[$];
    int             mismatches;
    int             cycle_count;
    int             hold_request;
    int             burst_left;
    sfdq_pkg::tag_t source_pool [12];

    function automatic void add_result(logic [3:0] st, int slot, logic [15:0] len,
                                       logic [15:0] hnd, logic np, logic lst);
        sfdq_pkg::out_t r;
        r.status     = st;
        r.out_slot   = slot[7:0];
        r.out_length = len;
        r.out_handle = hnd;
        r.new_peer   = np;
        r.last       = lst;
        pending_results.push_back(r);
    endfunction

    function automatic logic tag_hit(int s, sfdq_pkg::tag_t k);
        if (!peer_used[s] || peer_tag[s].family != k.family
            || peer_tag[s].src_port != k.src_port)
            return 1'b0;
        if (k.family == sfdq_pkg::FAM_IPV4)
            return peer_tag[s].addr_low[31:0] == k.addr_low[31:0];
        if (k.family == sfdq_pkg::FAM_IPV6)
            return peer_tag[s].addr_high == k.addr_high
                && peer_tag[s].addr_low == k.addr_low;
        return 1'b0;
    endfunction

    function automatic void predict_arrival(sfdq_pkg::in_t it);
        sfdq_pkg::tag_t k;
        int             slot;
        int             lim;
        int             pos;
        logic           np;
        logic [3:0]     st;
        logic [15:0]    rep;
        k.family    = it.family;
        k.addr_high = it.addr_high;
        k.addr_low  = it.addr_low;
        k.src_port  = it.src_port;
        slot = -1;
        np   = 1'b0;
        st   = sfdq_pkg::ST_QUEUED;
        rep  = it.pkt_handle;
        if (intake_shut)
        begin
            add_result(sfdq_pkg::ST_CLOSED, 0, 16'd0, it.pkt_handle, 1'b0, 1'b1);
            return;
        end
        for (int s = 0; s < sfdq_pkg::PEER_SLOTS && slot < 0; s++)
            if (tag_hit(s, k))
                slot = s;
        if (slot < 0)
        begin
            for (int s = 0; s < sfdq_pkg::PEER_SLOTS && slot < 0; s++)
                if (!peer_used[s])
                    slot = s;
            if (slot < 0)
            begin
                add_result(sfdq_pkg::ST_NO_SLOT, 0, 16'd0, it.pkt_handle, 1'b0, 1'b1);
                return;
            end
            peer_used[slot] = 1'b1;
            peer_tag[slot]  = k;
            peer_head[slot] = 0;
            peer_fill[slot] = 0;
            np = 1'b1;
            if (ring_fill < sfdq_pkg::PEER_SLOTS)
            begin
                accept_ring[(ring_head + ring_fill) % sfdq_pkg::PEER_SLOTS] = slot;
                ring_fill++;
            end
        end
        lim = (limit_reg == '0) ? 1 : ((int'(limit_reg) > sfdq_pkg::QUEUE_DEPTH)
              ? sfdq_pkg::QUEUE_DEPTH : int'(limit_reg));
        if (peer_fill[slot] >= lim && peer_fill[slot] > 0)
        begin
            rep = desc_store[slot*sfdq_pkg::QUEUE_DEPTH + peer_head[slot]].handle;
            peer_head[slot] = (peer_head[slot] + 1) % sfdq_pkg::QUEUE_DEPTH;
            peer_fill[slot]--;
            st = sfdq_pkg::ST_DROPPED;
        end
        pos = (peer_head[slot] + peer_fill[slot]) % sfdq_pkg::QUEUE_DEPTH;
        desc_store[slot*sfdq_pkg::QUEUE_DEPTH + pos].length = it.pkt_length;
        desc_store[slot*sfdq_pkg::QUEUE_DEPTH + pos].handle = it.pkt_handle;
        peer_fill[slot]++;
        add_result(st, slot, 16'd0, rep, np, 1'b1);
    endfunction

    function automatic void predict_item(sfdq_pkg::in_t it);
        int              ps;
        int              n;
        sfdq_pkg::desc_t d;
        ps = int'(it.peer_slot);
        case (it.op)
            sfdq_pkg::OP_ARRIVAL: predict_arrival(it);
            sfdq_pkg::OP_ACCEPT:
            begin
                if (intake_shut)
                    add_result(sfdq_pkg::ST_CLOSED, 0, 16'd0, 16'd0, 1'b0, 1'b1);
                else if (ring_fill == 0)
                    add_result(sfdq_pkg::ST_PENDING, 0, 16'd0, 16'd0, 1'b0, 1'b1);
                else
                begin
                    add_result(sfdq_pkg::ST_ACCEPTED, accept_ring[ring_head], 16'd0,
                               16'd0, 1'b0, 1'b1);
                    ring_head = (ring_head + 1) % sfdq_pkg::PEER_SLOTS;
                    ring_fill--;
                end
            end
            sfdq_pkg::OP_RECEIVE:
            begin
                if (!peer_used[ps])
                    add_result(sfdq_pkg::ST_CLOSED, ps, 16'd0, 16'd0, 1'b0, 1'b1);
                else if (peer_fill[ps] == 0)
                    add_result(sfdq_pkg::ST_EMPTY, ps, 16'd0, 16'd0, 1'b0, 1'b1);
                else
                begin
                    d = desc_store[ps*sfdq_pkg::QUEUE_DEPTH + peer_head[ps]];
                    if (d.length > it.capacity)
                        add_result(sfdq_pkg::ST_NEED_CAP, ps, d.length, 16'd0, 1'b0, 1'b1);
                    else
                    begin
                        peer_head[ps] = (peer_head[ps] + 1) % sfdq_pkg::QUEUE_DEPTH;
                        peer_fill[ps]--;
                        add_result(sfdq_pkg::ST_RECEIVED, ps, d.length, d.handle,
                                   1'b0, 1'b1);
                    end
                end
            end
            sfdq_pkg::OP_PCLOSE:
            begin
                n = peer_used[ps] ? peer_fill[ps] : 0;
                for (int i = 0; i < n; i++)
                begin
                    d = desc_store[ps*sfdq_pkg::QUEUE_DEPTH
                                   + (peer_head[ps] + i) % sfdq_pkg::QUEUE_DEPTH];
                    add_result(sfdq_pkg::ST_RELEASED, ps, d.length, d.handle, 1'b0,
                               i + 1 == n);
                end
                peer_fill[ps] = 0;
                peer_head[ps] = 0;
                peer_used[ps] = 1'b0;
                if (n == 0)
                    add_result(sfdq_pkg::ST_CLOSE_DONE, ps, 16'd0, 16'd0, 1'b0, 1'b1);
            end
            sfdq_pkg::OP_LCLOSE:
            begin
                intake_shut = 1'b1;
                add_result(sfdq_pkg::ST_CLOSE_DONE, 0, 16'd0, 16'd0, 1'b0, 1'b1);
            end
            default: ;
        endcase
    endfunction

    // result checker
    always @(posedge clk)
    begin
        sfdq_pkg::out_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", out_data);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (exp_r !== out_data)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result differs: expected %p actual %p", exp_r, out_data);
                end
            end
        end
    end

    // receiver stall pattern, with a long hold-off on request
    always @(posedge clk)
    begin
        int hold_cnt;
        int mode_cnt;
        int mode;
        if (hold_request > 0)
        begin
            hold_cnt     = hold_request;
            hold_request = 0;
        end
        mode_cnt++;
        if (mode_cnt >= 64)
        begin
            mode_cnt = 0;
            mode     = $urandom_range(0, 3);
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_stall <= 1'b1;
        end
        else
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 9) < 3);
                2: out_stall <= ($urandom_range(0, 9) < 7);
                default: out_stall <= mode_cnt[1];
            endcase
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("source_flow_demux_queues_unit: mismatch");
            $finish;
        end
    end

    task automatic send_item(sfdq_pkg::in_t it);
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
        predict_item(it);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 20);
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_limit(logic [sfdq_pkg::LIMIT_W-1:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_reg = v;
        @(posedge clk);
    endtask

    function automatic sfdq_pkg::in_t make_item(logic [2:0] op, int slot);
        sfdq_pkg::in_t it;
        it            = '0;
        it.op         = op;
        it.peer_slot  = slot[7:0];
        it.capacity   = 16'($urandom);
        it.pkt_length = 16'($urandom_range(0, 2000));
        it.pkt_handle = 16'($urandom);
        return it;
    endfunction

    function automatic sfdq_pkg::in_t arrival_from(sfdq_pkg::tag_t t);
        sfdq_pkg::in_t it;
        it           = make_item(sfdq_pkg::OP_ARRIVAL, 0);
        it.family    = t.family;
        it.addr_high = t.addr_high;
        it.addr_low  = t.addr_low;
        it.src_port  = t.src_port;
        // ipv4 ignores everything above the low 32 address bits
        if (t.family == sfdq_pkg::FAM_IPV4)
        begin
            it.addr_high = {$urandom, $urandom};
            it.addr_low[63:32] = $urandom;
        end
        return it;
    endfunction

    function automatic sfdq_pkg::in_t random_arrival();
        sfdq_pkg::in_t it;
        it           = make_item(sfdq_pkg::OP_ARRIVAL, 0);
        it.family    = 2'($urandom_range(0, 3));
        it.addr_high = {$urandom, $urandom};
        it.addr_low  = {$urandom, $urandom};
        it.src_port  = 16'($urandom);
        it.pkt_length = 16'($urandom);
        return it;
    endfunction

    task automatic test_basic_ops();
        sfdq_pkg::in_t it;
        send_item(make_item(sfdq_pkg::OP_ACCEPT, 0));
        send_item(make_item(sfdq_pkg::OP_RECEIVE, 0));
        send_item(make_item(sfdq_pkg::OP_PCLOSE, 255));
        it = make_item(sfdq_pkg::OP_ARRIVAL, 0);
        it.family     = sfdq_pkg::FAM_IPV4;
        it.addr_high  = '1;
        it.addr_low   = '1;
        it.src_port   = 16'hffff;
        it.pkt_length = 16'hffff;
        it.pkt_handle = 16'hffff;
        send_item(it);
        it.addr_high       = '0;
        it.addr_low[63:32] = '0;
        it.pkt_length      = 16'd10;
        send_item(it);
        it = make_item(sfdq_pkg::OP_ARRIVAL, 0);
        it.family     = sfdq_pkg::FAM_IPV6;
        it.pkt_length = 16'd0;
        it.pkt_handle = 16'd0;
        send_item(it);
        it.addr_high = 64'h8000_0000_0000_0000;
        send_item(it);
        it.family = 2'd2;
        send_item(it);
        send_item(it);
        it.family = 2'd3;
        send_item(it);
        send_item(make_item(sfdq_pkg::OP_ACCEPT, 0));
        it = make_item(sfdq_pkg::OP_RECEIVE, 0);
        it.capacity = 16'd0;
        send_item(it);
        it.capacity = 16'hffff;
        send_item(it);
        it = make_item(sfdq_pkg::OP_RECEIVE, 1);
        it.capacity = 16'd0;
        send_item(it);
        send_item(it);
        send_item(make_item(sfdq_pkg::OP_PCLOSE, 0));
        send_item(make_item(3'd5, 0));
        send_item(make_item(3'd6, 0));
        send_item(make_item(3'd7, 0));
        for (int s = 1; s < 6; s++)
            send_item(make_item(sfdq_pkg::OP_PCLOSE, s));
    endtask

    task automatic test_queue_limits();
        sfdq_pkg::in_t  it;
        sfdq_pkg::tag_t t;
        it = random_arrival();
        t.family    = sfdq_pkg::FAM_IPV6;
        t.addr_high = it.addr_high;
        t.addr_low  = it.addr_low;
        t.src_port  = it.src_port;
        write_limit(7'd1);
        repeat (3) send_item(arrival_from(t));
        write_limit(7'd0);
        repeat (2) send_item(arrival_from(t));
        write_limit(7'd3);
        repeat (5) send_item(arrival_from(t));
        write_limit(7'd127);
        // fill past the queue depth, then release a full list
        repeat (64) send_item(arrival_from(t));
        send_item(make_item(sfdq_pkg::OP_PCLOSE, 0));
        write_limit(7'd64);
    endtask

    task automatic test_table_full();
        // every slot taken, then the ring is full when a freed slot is reused
        for (int i = 0; i < sfdq_pkg::PEER_SLOTS + 2; i++)
            send_item(random_arrival());
        send_item(make_item(sfdq_pkg::OP_PCLOSE, 37));
        send_item(random_arrival());
        // the reused slot must not overwrite the ring head
        send_item(make_item(sfdq_pkg::OP_ACCEPT, 0));
        for (int s = 0; s < 8; s++)
            send_item(make_item(sfdq_pkg::OP_PCLOSE, s));
    endtask

    task automatic test_backpressure();
        hold_request = 600;
        repeat (8) send_item(arrival_from(source_pool[$urandom_range(0, 3)]));
        repeat (4) send_item(make_item(sfdq_pkg::OP_RECEIVE, $urandom_range(0, 4)));
    endtask

    task automatic test_random_traffic();
        int            pick;
        sfdq_pkg::in_t it;
        for (int i = 0; i < 12; i++)
        begin
            source_pool[i].family    = 2'($urandom_range(0, 3));
            source_pool[i].addr_high = {$urandom, $urandom};
            source_pool[i].addr_low  = {$urandom, $urandom};
            source_pool[i].src_port  = 16'($urandom);
        end
        for (int i = 0; i < 40; i++)
        begin
            if (i == 13)
                write_limit(7'd4);
            if (i == 27)
                write_limit(7'd2);
            pick = $urandom_range(0, 99);
            if (pick < 42)
                send_item(arrival_from(source_pool[$urandom_range(0, 11)]));
            else if (pick < 50)
                send_item(random_arrival());
            else if (pick < 60)
                send_item(make_item(sfdq_pkg::OP_ACCEPT, 0));
            else if (pick < 82)
            begin
                it = make_item(sfdq_pkg::OP_RECEIVE, $urandom_range(0, 15));
                if ($urandom_range(0, 3) == 0)
                    it.capacity = 16'($urandom_range(0, 1000));
                send_item(it);
            end
            else if (pick < 90)
                send_item(make_item(sfdq_pkg::OP_PCLOSE, $urandom_range(0, 15)));
            else if (pick < 94)
                send_item(make_item(sfdq_pkg::OP_RECEIVE, $urandom_range(0, 255)));
            else if (pick < 97)
                send_item(make_item(sfdq_pkg::OP_PCLOSE, $urandom_range(0, 255)));
            else
            begin
                it = random_arrival();
                it.op = 3'($urandom_range(5, 7));
                it.peer_slot = 8'($urandom);
                it.capacity = 16'($urandom);
                send_item(it);
            end
        end
        write_limit(7'd64);
    endtask

    task automatic test_listener_close();
        sfdq_pkg::in_t it;
        send_item(make_item(sfdq_pkg::OP_LCLOSE, 0));
        send_item(random_arrival());
        send_item(make_item(sfdq_pkg::OP_ACCEPT, 0));
        it = make_item(sfdq_pkg::OP_RECEIVE, 0);
        it.capacity = 16'hffff;
        send_item(it);
        for (int s = 0; s < 4; s++)
            send_item(make_item(sfdq_pkg::OP_PCLOSE, s));
    endtask

    initial
    begin
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        for (int s = 0; s < sfdq_pkg::PEER_SLOTS; s++)
        begin
            peer_used[s] = 1'b0;
            peer_head[s] = 0;
            peer_fill[s] = 0;
        end
        ring_head    = 0;
        ring_fill    = 0;
        intake_shut  = 1'b0;
        limit_reg    = sfdq_pkg::LIMIT_RESET;
        mismatches   = 0;
        cycle_count  = 0;
        hold_request = 0;
        burst_left   = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_queue_limits();
        test_table_full();
        test_random_traffic();
        test_backpressure();
        test_listener_close();

        wait_idle();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("source_flow_demux_queues_unit: match");
        else
            $display("source_flow_demux_queues_unit: mismatch");
        $finish;
    end

endmodule
